// ===== design/bba_pkg.sv =====
// Package for the buddy block allocator: flag bit positions, controller command
// and status structs. No dependencies.
`timescale 1ns / 1ps
package bba_pkg;
  localparam int FLAG_BITS = 3;
  localparam int F_SPLIT = 0;
  localparam int F_USED  = 1;
  localparam int F_FULL  = 2;
  localparam int REQ_W   = 15;
  localparam int OFF_W   = 14;

  typedef struct packed {
    logic load;      // latch request, compute level
    logic scan_rd;   // read flags at scan pointer
    logic scan_adv;  // step scan pointer
    logic sub_init;  // start subtree walk at found node
    logic sub_wr;    // write subtree node, advance
    logic anc_step;  // move to parent, read parent's first child
    logic anc_rd2;   // read second child
    logic anc_wr;    // write parent flags
    logic res_load;  // capture result
  } bba_cmd_t;

  typedef struct packed {
    logic too_large;
    logic scan_done;   // pointer past level end
    logic scan_hit;    // read node not in use
    logic sub_done;    // subtree walk past last node
    logic at_root;
  } bba_sts_t;
endpackage

// ===== design/bba_datapath.sv =====
// Datapath of the buddy block allocator: request rounding, node flag/owner
// memories, scan and subtree/ancestor pointers. Uses bba_pkg.
`timescale 1ns / 1ps
module bba_datapath #(
  parameter int PAGES      = 256,
  parameter int PAGE_BYTES = 64,
  parameter int OWNER_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bba_pkg::bba_cmd_t    cmd,
  output bba_pkg::bba_sts_t    sts,
  input  logic [14:0]          req_bytes,
  input  logic [7:0]           owner_in,
  output logic                 res_granted,
  output logic [13:0]          res_offset,
  output logic [14:0]          res_bytes
);
  import bba_pkg::*;
  localparam int NODES = 2 * PAGES - 1;
  localparam int NW    = $clog2(NODES + 1) + 1;
  localparam int LVW   = $clog2(PAGES) + 1;
  localparam int OWN_W = (OWNER_BITS < 8) ? OWNER_BITS : 8;

  logic [FLAG_BITS-1:0]  flags_mem [NODES];
  logic [OWNER_BITS-1:0] owner_mem [NODES];

  logic [NW-1:0]  span_r, ptr_r, end_r, first_r, cnt_r, k_r, found_r, par_r;
  logic [NW-1:0]  lvl_cnt_r;
  logic [OWN_W-1:0] owner_r;
  logic [FLAG_BITS-1:0] rd_r, c1_r;
  logic [FLAG_BITS-1:0] par_flags_r;
  logic            clr_r;   // reset clearing pass active
  logic [NW-1:0]  clr_ptr_r;
  logic            big_r;

  // Rounding: span = smallest power-of-two page count with span*PAGE_BYTES >= req
  logic [NW-1:0]  span_c, lvl_cnt_c;
  logic            big_c;
  always_comb begin
    logic [31:0] rq;
    rq = {17'd0, req_bytes};
    span_c    = NW'(1);
    lvl_cnt_c = NW'(PAGES);
    big_c     = 1'b0;
    for (int l = 0; l <= $clog2(PAGES); l++) begin
      if (32'(PAGE_BYTES) * (32'(1) << (LVW - 1 - l)) >= rq) begin
        span_c    = NW'(32'(1) << (LVW-1-l));
        lvl_cnt_c = NW'(32'(1) << l);
      end
    end
    if (32'(PAGE_BYTES) * 32'(PAGES) < rq) big_c = 1'b1;
  end

  logic [NW-1:0] sub_node;
  assign sub_node = first_r + k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      clr_ptr_r <= '0;
    end else if (clr_r) begin
      flags_mem[clr_ptr_r[NW-2:0]] <= '0;
      clr_ptr_r <= clr_ptr_r + NW'(1);
      if (clr_ptr_r == NW'(NODES - 1)) clr_r <= 1'b0;
    end else begin
      if (cmd.sub_wr) begin
        flags_mem[sub_node[NW-2:0]] <= FLAG_BITS'((1 << F_USED) | (1 << F_FULL));
        owner_mem[sub_node[NW-2:0]] <= OWNER_BITS'(owner_r);
      end
      if (cmd.anc_wr)
        flags_mem[par_r[NW-2:0]] <= par_flags_r | FLAG_BITS'((1 << F_SPLIT) | (1 << F_USED))
          | ((c1_r[F_FULL] && rd_r[F_FULL]) ? FLAG_BITS'(1 << F_FULL) : '0);
    end
  end

  // rd_r: read port; during anc steps holds first child flags, then second child
  logic [NW-1:0] rd_addr;
  always_comb begin
    rd_addr = ptr_r;
    if (cmd.anc_step) rd_addr = NW'(2) * ((found_r - NW'(1)) >> 1) + NW'(1);
    else if (cmd.anc_rd2) rd_addr = NW'(2) * par_r + NW'(2);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.anc_step || cmd.anc_rd2)
      rd_r <= flags_mem[rd_addr[NW-2:0]];
    if (cmd.anc_step) c1_r <= flags_mem[rd_addr[NW-2:0]];
  end
  // anc_wr needs parent's own flags too: combine via separate read
  always_ff @(posedge clk) begin
    if (cmd.anc_rd2) par_flags_r <= flags_mem[par_r[NW-2:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      span_r    <= span_c;
      lvl_cnt_r <= lvl_cnt_c;
      big_r     <= big_c;
      owner_r   <= OWN_W'(owner_in);
      ptr_r     <= lvl_cnt_c - NW'(1);
      end_r     <= NW'(2) * lvl_cnt_c - NW'(1);
    end
    if (cmd.scan_adv) ptr_r <= ptr_r + NW'(1);
    if (cmd.sub_init) begin
      found_r <= ptr_r;
      first_r <= ptr_r;
      cnt_r   <= NW'(1);
      k_r     <= '0;
    end
    if (cmd.sub_wr) begin
      if (k_r + NW'(1) >= cnt_r) begin
        first_r <= NW'(2) * first_r + NW'(1);
        cnt_r   <= cnt_r << 1;
        k_r     <= '0;
      end else k_r <= k_r + NW'(1);
    end
    if (cmd.anc_step) par_r <= (found_r - NW'(1)) >> 1;
    if (cmd.anc_wr) found_r <= par_r;
    if (cmd.res_load) begin
      res_granted <= !big_r && ptr_r != end_r;
      res_bytes   <= big_r ? '0 : 15'(32'(span_r) * 32'(PAGE_BYTES));
      res_offset  <= (big_r || ptr_r == end_r) ? '0
        : 14'(32'(ptr_r - (lvl_cnt_r - NW'(1))) * 32'(span_r) * 32'(PAGE_BYTES));
    end
  end

  assign sts.too_large = big_r;
  assign sts.scan_done = ptr_r == end_r;
  assign sts.scan_hit  = !rd_r[F_USED];
  assign sts.sub_done  = first_r >= NW'(NODES);
  assign sts.at_root   = found_r == '0;
endmodule

// ===== design/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: stream ports, controller FSM.
// Uses bba_pkg and bba_datapath.
//   channel | dir | tdata fields (low bit up)
//   in_     | in  | request_bytes[14:0], owner_id[22:15]
//   out_    | out | granted[0], block_offset[14:1], block_bytes[29:15]
// One request at a time: accept, scan of one level (states S_RD and S_CHK per node),
// subtree write (one node a cycle), ancestor walk (states S_ANC1, S_ANC2, S_ANC3 per
// level), result, then out_tvalid until out_tready.
// After reset a clearing pass runs; in_tready stays low until it ends.
`timescale 1ns / 1ps
module buddy_block_allocator #(
  parameter int PAGES      = 256,
  parameter int PAGE_BYTES = 64,
  parameter int OWNER_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // request_bytes, owner_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // granted, block_offset, block_bytes
);
  import bba_pkg::*;
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_CHK = 4'd3,
    S_SUB = 4'd4, S_ANC1 = 4'd5, S_ANC2 = 4'd6, S_ANC3 = 4'd7, S_RES = 4'd8,
    S_OUT = 4'd9;
  localparam int CLR_W = $clog2(2 * PAGES) + 1;

  logic [3:0] state_r, state_nxt;
  logic [CLR_W-1:0] clr_cnt_r;
  bba_cmd_t cmd;
  bba_sts_t sts;
  logic g; logic [13:0] off; logic [14:0] byt;

  bba_datapath #(.PAGES(PAGES), .PAGE_BYTES(PAGE_BYTES), .OWNER_BITS(OWNER_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .req_bytes(in_tdata[14:0]), .owner_in(in_tdata[22:15]),
    .res_granted(g), .res_offset(off), .res_bytes(byt));

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_cnt_r == CLR_W'(2 * PAGES - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_tvalid) begin
        cmd.load = 1'b1; state_nxt = S_RD;
      end
      S_RD: begin
        if (sts.too_large || sts.scan_done) state_nxt = S_RES;
        else begin cmd.scan_rd = 1'b1; state_nxt = S_CHK; end
      end
      S_CHK: if (sts.scan_hit) begin
        cmd.sub_init = 1'b1; state_nxt = S_SUB;
      end else begin
        cmd.scan_adv = 1'b1; state_nxt = S_RD;
      end
      S_SUB: if (sts.sub_done) state_nxt = sts.at_root ? S_RES : S_ANC1;
        else cmd.sub_wr = 1'b1;
      S_ANC1: if (sts.at_root) state_nxt = S_RES;
        else begin cmd.anc_step = 1'b1; state_nxt = S_ANC2; end
      S_ANC2: begin cmd.anc_rd2 = 1'b1; state_nxt = S_ANC3; end
      S_ANC3: begin
        cmd.anc_wr = 1'b1; state_nxt = S_ANC1;
      end
      S_RES:  begin cmd.res_load = 1'b1; state_nxt = S_OUT; end
      S_OUT:  if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_cnt_r <= clr_cnt_r + CLR_W'(1);
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = state_r == S_OUT;
  assign out_tdata  = {2'b00, byt, off, g};

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("busy and idle together");
  a_deny_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[14:1] == 14'd0) else $error("offset on deny");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_RD) else $error("no start");
endmodule
